// ===== hw/rtl/hrsd_pkg.sv =====
// shared types and constants of the hid report stream deframer
package hrsd_pkg;

	// result queue sizing
	localparam int FIFO_DEPTH_DEF = 8;
	localparam int MAX_RESULTS    = 3;
	localparam int BATCH_CNT_W    = 2;

	// report ids
	localparam logic [7:0] ID_PANEL = 8'd3;
	localparam logic [7:0] ID_CMD   = 8'd6;

	// bit positions in the flags byte
	localparam int FLAG_END_BIT   = 0;
	localparam int FLAG_FIN_BIT   = 1;
	localparam int FLAG_START_BIT = 2;
	localparam int FLAG_INFO_BIT  = 7;

	// device-info record layout
	localparam logic [7:0] ASCII_ONE  = 8'h31;
	localparam logic [7:0] INFO_LEN   = 8'd23;
	localparam logic [7:0] PLAYER_POS = 8'd2;
	localparam logic [7:0] FW_LO_POS  = 8'd20;
	localparam logic [7:0] FW_HI_POS  = 8'd21;
	localparam logic [7:0] POS_MAX    = 8'hFF;

	// kinds of output events
	typedef enum logic [2:0] {
		EV_PANEL     = 3'd0,
		EV_CMD_BYTE  = 3'd1,
		EV_DISCARD   = 3'd2,
		EV_FINISHED  = 3'd3,
		EV_MSG_DONE  = 3'd4,
		EV_INFO_BYTE = 3'd5,
		EV_INFO_DONE = 3'd6
	} ev_kind_t;

	// one output request
	typedef struct packed {
		ev_kind_t    kind;
		logic [15:0] data;
		logic        player_two;
		logic        last;
	} result_t;

	// all results produced by one input byte
	typedef struct packed {
		logic [BATCH_CNT_W-1:0]       count;
		result_t [MAX_RESULTS-1:0]    res;
	} batch_t;

endpackage

// ===== hw/rtl/hrsd_parser.sv =====
// report parser: framing state and per-byte result generation
module hrsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [7:0]       rx_byte_s1,
	input  logic             active,
	output hrsd_pkg::batch_t batch
);
	import hrsd_pkg::*;

	typedef enum logic [7:0] {
		PH_ID    = 8'b0000_0001,
		PH_LOW   = 8'b0000_0010,
		PH_HIGH  = 8'b0000_0100,
		PH_FLAGS = 8'b0000_1000,
		PH_SIZE  = 8'b0001_0000,
		PH_CMD   = 8'b0010_0000,
		PH_INFO  = 8'b0100_0000,
		PH_SKIP  = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  rem_q, rem_d;
	logic [7:0]  pos_q, pos_d;
	logic        pn_q, pn_d;
	logic [15:0] fw_q, fw_d;
	logic        p2_q, p2_d;

	logic [7:0]  rem_dec;
	logic        first_en, done_en, eoc, fin_en, msg_en;
	ev_kind_t    first_kind;
	logic [15:0] first_data;
	logic [BATCH_CNT_W-1:0] n;
	result_t [MAX_RESULTS-1:0] res;

	// next state and event selection for the byte in the input register
	always_comb begin
		phase_d    = phase_q;
		held_d     = held_q;
		flags_d    = flags_q;
		rem_d      = rem_q;
		pos_d      = pos_q;
		pn_d       = pn_q;
		fw_d       = fw_q;
		p2_d       = p2_q;
		first_en   = 1'b0;
		first_kind = EV_PANEL;
		first_data = '0;
		done_en    = 1'b0;
		eoc        = 1'b0;
		fin_en     = 1'b0;
		msg_en     = 1'b0;
		rem_dec    = (rem_q == 8'd0) ? 8'd0 : rem_q - 8'd1;
		unique case (phase_q)
			PH_ID: begin
				if (rx_byte_s1 == ID_PANEL) begin
					phase_d = PH_LOW;
				end else if (rx_byte_s1 == ID_CMD) begin
					phase_d = PH_FLAGS;
				end
			end
			PH_LOW: begin
				held_d  = rx_byte_s1;
				phase_d = PH_HIGH;
			end
			PH_HIGH: begin
				first_en   = 1'b1;
				first_kind = EV_PANEL;
				first_data = {rx_byte_s1, held_q};
				phase_d    = PH_ID;
			end
			PH_FLAGS: begin
				flags_d = rx_byte_s1;
				phase_d = PH_SIZE;
			end
			PH_SIZE: begin
				rem_d = rx_byte_s1;
				pos_d = 8'd0;
				if (flags_q[FLAG_INFO_BIT]) begin
					fw_d = '0;
					p2_d = 1'b0;
					if (rx_byte_s1 == 8'd0) begin
						done_en = 1'b1;
						phase_d = PH_ID;
					end else begin
						phase_d = PH_INFO;
					end
				end else if (active) begin
					if (flags_q[FLAG_START_BIT] && pn_q) begin
						first_en   = 1'b1;
						first_kind = EV_DISCARD;
						pn_d       = 1'b0;
					end
					if (rx_byte_s1 == 8'd0) begin
						eoc     = 1'b1;
						phase_d = PH_ID;
					end else begin
						phase_d = PH_CMD;
					end
				end else begin
					phase_d = (rx_byte_s1 == 8'd0) ? PH_ID : PH_SKIP;
				end
			end
			PH_CMD: begin
				first_en   = 1'b1;
				first_kind = EV_CMD_BYTE;
				first_data = {8'd0, rx_byte_s1};
				pn_d       = 1'b1;
				rem_d      = rem_dec;
				if (rem_dec == 8'd0) begin
					eoc     = 1'b1;
					phase_d = PH_ID;
				end
			end
			PH_INFO: begin
				if (pos_q < INFO_LEN) begin
					first_en   = 1'b1;
					first_kind = EV_INFO_BYTE;
					first_data = {8'd0, rx_byte_s1};
					if (pos_q == PLAYER_POS) begin
						p2_d = (rx_byte_s1 == ASCII_ONE);
					end else if (pos_q == FW_LO_POS) begin
						fw_d[7:0] = rx_byte_s1;
					end else if (pos_q == FW_HI_POS) begin
						fw_d[15:8] = rx_byte_s1;
					end
				end
				if (pos_q != POS_MAX) begin
					pos_d = pos_q + 8'd1;
				end
				rem_d = rem_dec;
				if (rem_dec == 8'd0) begin
					done_en = 1'b1;
					phase_d = PH_ID;
				end
			end
			PH_SKIP: begin
				rem_d = rem_dec;
				if (rem_dec == 8'd0) begin
					phase_d = PH_ID;
				end
			end
			default: begin
				phase_d = PH_ID;
			end
		endcase
		// end-of-command framing events
		if (eoc) begin
			fin_en = flags_q[FLAG_FIN_BIT];
			if (flags_q[FLAG_END_BIT]) begin
				msg_en = pn_d;
				pn_d   = 1'b0;
			end
		end
	end

	// pack the enabled events in order and mark the final one
	always_comb begin
		n   = '0;
		res = '0;
		if (first_en) begin
			res[n].kind = first_kind;
			res[n].data = first_data;
			n = n + 1'b1;
		end
		if (done_en) begin
			res[n].kind       = EV_INFO_DONE;
			res[n].data       = fw_d;
			res[n].player_two = p2_d;
			n = n + 1'b1;
		end
		if (fin_en) begin
			res[n].kind = EV_FINISHED;
			n = n + 1'b1;
		end
		if (msg_en) begin
			res[n].kind = EV_MSG_DONE;
			n = n + 1'b1;
		end
		if (n != '0) begin
			res[n - 1'b1].last = 1'b1;
		end
	end

	assign batch.count = en ? n : '0;
	assign batch.res   = res;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			held_q  <= '0;
			flags_q <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
			pn_q    <= 1'b0;
			fw_q    <= '0;
			p2_q    <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			flags_q <= flags_d;
			rem_q   <= rem_d;
			pos_q   <= pos_d;
			pn_q    <= pn_d;
			fw_q    <= fw_d;
			p2_q    <= p2_d;
		end
	end

endmodule

// ===== hw/rtl/hrsd_result_fifo.sv =====
// result queue: takes up to three results per cycle, hands out one while out_stall is low
module hrsd_result_fifo #(
	parameter int DEPTH = hrsd_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hrsd_pkg::batch_t  push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output hrsd_pkg::result_t head
);
	import hrsd_pkg::*;

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int COUNT_W = $clog2(DEPTH + 1);

	result_t              mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign head      = mem_q[rd_ptr_q];
	// enough free entries for the largest batch
	assign room      = (count_q <= COUNT_W'(DEPTH - MAX_RESULTS));

	// entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (BATCH_CNT_W'(i) < push.count) begin
				mem_q[wr_ptr_q + PTR_W'(i)] <= push.res[i];
			end
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + COUNT_W'(push.count) - COUNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("result queue fill level above depth");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != '0) |-> room)
		else $error("results pushed without room for a full batch");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + COUNT_W'($past(push.count))
			- COUNT_W'($past(pop)))
		else $error("result queue fill level lost track of pushes and pops");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		PTR_W'(count_q) == PTR_W'(wr_ptr_q - rd_ptr_q))
		else $error("result queue pointers disagree with fill level");

endmodule

// ===== hw/rtl/hid_report_stream_deframer.sv =====
// top level: input register, report parser and result queue
// path: an accepted byte waits in the input register until the queue has room, is
//   parsed there, and its results enter the result queue, whose head drives out_valid
// throughput: one byte per cycle; input stalls while the queue lacks room for a full
//   batch; a byte yields up to three results, drained one per cycle while out_stall is low
// reset: arst_n clears the parser to waiting for a report id, empties the queue, active_q = 0
module hid_report_stream_deframer #(
	parameter int FIFO_DEPTH = hrsd_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [15:0] data,
	output logic        player_two,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        active
);
	import hrsd_pkg::*;

	logic       valid_s1, valid_s1_d;
	logic [7:0] rx_byte_s1;
	logic       active_q;
	logic       room;
	logic       advance;
	logic       in_accept;
	batch_t     batch;
	result_t    head;

	assign advance   = valid_s1 & room;
	assign in_stall  = valid_s1 & ~room;
	assign in_accept = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	// input register
	always_comb begin
		valid_s1_d = valid_s1;
		if (in_accept) begin
			valid_s1_d = 1'b1;
		end else if (advance) begin
			valid_s1_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_s1_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= active;
		end
	end

	hrsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.rx_byte_s1 (rx_byte_s1),
		.active     (active_q),
		.batch      (batch)
	);

	hrsd_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (batch),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// output fields
	assign event_kind = head.kind;
	assign data       = head.data;
	assign player_two = head.player_two;
	assign last       = head.last;

endmodule
